### rtl/acs_pkg.sv
`default_nettype none
package acs_pkg;

   localparam int SLOT_W         = 10;
   localparam int SCORE_W        = 24;
   localparam int BASE_W         = 16;
   localparam int LIST_DEPTH_DEF = 64;
   localparam int SLOT_COUNT_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_END   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic [SLOT_W-1:0]  slot;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic shift_left;
      logic insert;
   } cell_ctl_type;

   typedef struct packed {
      logic le;
      logic lt;
      logic dom;
      logic rem;
      logic bnd;
      logic last;
   } cell_flag_type;

   typedef struct packed {
      logic               found;
      logic [SCORE_W-1:0] score;
      logic [SLOT_W-1:0]  slot;
   } pick_type;

endpackage
`default_nettype wire

### rtl/acs_ram.sv
`default_nettype none
module acs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/acs_cell.sv
`default_nettype none
module acs_cell import acs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [COORD_BITS-1:0] key_y,
   input  logic [SCORE_W-1:0]    key_sc,
   input  logic [COORD_BITS-1:0] new_ey,
   input  entry_type             new_ent,
   input  logic [COORD_BITS-1:0] left_ey,
   input  entry_type             left_ent,
   input  logic                  left_lt,
   input  logic [COORD_BITS-1:0] right_ey,
   input  entry_type             right_ent,
   input  logic                  right_le,
   output logic [COORD_BITS-1:0] ey,
   output entry_type             ent,
   output cell_flag_type         flags
);

   logic [COORD_BITS-1:0] ey_ff, ey_in;
   entry_type             ent_ff, ent_in;
   logic                  le, lt, at_m;

   always_comb begin
      le   = ent_ff.valid && (ey_ff <= key_y);
      lt   = ent_ff.valid && (ey_ff < key_y);
      // first cell at or past the key
      at_m = !lt && left_lt;

      flags.le   = le;
      flags.lt   = lt;
      flags.bnd  = le && !right_le;
      flags.dom  = le && !right_le && (ent_ff.score >= key_sc);
      flags.rem  = at_m && ent_ff.valid && (ent_ff.score < key_sc);
      flags.last = ent_ff.valid && !right_ent.valid;

      priority if (ctl.clear) begin
         ey_in        = ey_ff;
         ent_in       = ent_ff;
         ent_in.valid = 1'b0;
      end else if (ctl.shift_left && !lt) begin
         ey_in  = right_ey;
         ent_in = right_ent;
      end else if (ctl.insert && at_m) begin
         ey_in  = new_ey;
         ent_in = new_ent;
      end else if (ctl.insert && !left_lt) begin
         ey_in  = left_ey;
         ent_in = left_ent;
      end else begin
         ey_in  = ey_ff;
         ent_in = ent_ff;
      end
   end

   always_ff @(posedge clock) begin
      ey_ff        <= ey_in;
      ent_ff.score <= ent_in.score;
      ent_ff.slot  <= ent_in.slot;
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
   end

   assign ey  = ey_ff;
   assign ent = ent_ff;

endmodule
`default_nettype wire

### rtl/acs_pick.sv
`default_nettype none
module acs_pick import acs_pkg::*; #(
   parameter int DEPTH = LIST_DEPTH_DEF
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] sel,
   input  entry_type        ent [DEPTH],
   output pick_type         pick
);

   pick_type pick_ff, pick_in;

   // one-hot select, AND-OR reduction
   always_comb begin
      pick_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_in.score = pick_in.score | (ent[i].score & {SCORE_W{sel[i]}});
         pick_in.slot  = pick_in.slot  | (ent[i].slot  & {SLOT_W{sel[i]}});
      end
      pick_in.found = |sel;
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
   end

   assign pick = pick_ff;

endmodule
`default_nettype wire

### rtl/alignment_chaining_sweep.sv
// Sparse chaining sweep: feed start/end events in x order (ends before starts at equal x).
// The dominance list lives in a row of LIST_DEPTH cells, sorted by end y, each comparing
// against the event key in parallel and shifting to its neighbors; chained scores per slot
// sit in a SLOT_COUNT-deep RAM with no reset (an end event must follow its slot's start).
// One event at a time: a start event steps through LOOK, CALC, BEST and FIN, clear and
// unused codes and a dominated end event through LOOK, BEST and FIN, and an inserted or
// overflowing end event through LOOK, DEL (held while displaced entries are removed), BEST
// and FIN; the list collapses one entry per cycle through the cell row, and the predecessor
// and best-entry lookups each pass through a registered one-hot select over all cells. A
// finished result waits in the rsp register while the next event is accepted.
`default_nettype none
module alignment_chaining_sweep import acs_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [BASE_W-1:0]     req_base_score,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pred_valid,
   output logic [SLOT_W-1:0]     rsp_pred_slot,
   output logic [SCORE_W-1:0]    rsp_chain_score,
   output logic                  rsp_inserted,
   output logic                  rsp_overflow,
   output logic                  rsp_best_valid,
   output logic [SCORE_W-1:0]    rsp_best_score,
   output logic [SLOT_W-1:0]     rsp_best_slot
);

   localparam int IDX_W = $clog2(SLOT_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_CALC,
      S_DEL,
      S_BEST,
      S_FIN
   } state_type;

   function automatic logic [IDX_W-1:0] slot_index(input logic [SLOT_W-1:0] slot);
      logic [31:0] r;
      r = 32'(slot);
      for (int k = SLOT_W - 1; k >= 0; k--) begin
         if (r >= (32'(SLOT_COUNT) << k)) begin
            r = r - (32'(SLOT_COUNT) << k);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   state_type                state_ff, state_in;
   action_type               action_ff, action_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [COORD_BITS-1:0]    y_ff, y_in;
   logic [BASE_W-1:0]        base_ff, base_in;
   logic [SCORE_W-1:0]       sc_ff, sc_in;
   logic                     pv_ff, pv_in;
   logic [SLOT_W-1:0]        ps_ff, ps_in;
   logic [SCORE_W-1:0]       cs_ff, cs_in;
   logic                     ins_ff, ins_in;
   logic                     ovf_ff, ovf_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_pv_ff, rsp_pv_in;
   logic [SLOT_W-1:0]        rsp_ps_ff, rsp_ps_in;
   logic [SCORE_W-1:0]       rsp_cs_ff, rsp_cs_in;
   logic                     rsp_ins_ff, rsp_ins_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic                     rsp_bv_ff, rsp_bv_in;
   logic [SCORE_W-1:0]       rsp_bs_ff, rsp_bs_in;
   logic [SLOT_W-1:0]        rsp_bsl_ff, rsp_bsl_in;

   logic                     req_xfer;
   logic                     ram_wr_en;
   logic [SCORE_W-1:0]       ram_rd;
   logic [SCORE_W:0]         sum;
   logic [SCORE_W-1:0]       sat_score;
   logic [SCORE_W-1:0]       key_sc;
   entry_type                new_ent;
   cell_ctl_type             ctl;
   pick_type                 pick;
   logic [LIST_DEPTH-1:0]    pick_sel;

   logic [COORD_BITS-1:0]    cell_ey   [LIST_DEPTH];
   entry_type                cell_ent  [LIST_DEPTH];
   cell_flag_type            cell_flag [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]    bnd_vec, last_vec, dom_vec, rem_vec;
   logic                     dom_any, rem_any, full;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   acs_ram #(
      .WIDTH(SCORE_W),
      .DEPTH(SLOT_COUNT)
   ) u_score_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(idx_ff),
      .wr_data(sat_score),
      .rd_en  (req_xfer),
      .rd_addr(slot_index(req_slot)),
      .rd_data(ram_rd)
   );

   assign key_sc  = (state_ff == S_LOOK) ? ram_rd : sc_ff;
   assign new_ent = '{valid: 1'b1, score: sc_ff, slot: slot_ff};

   assign ctl.clear      = (state_ff == S_LOOK) && (action_ff == ACT_CLEAR);
   assign ctl.shift_left = (state_ff == S_DEL) && rem_any;
   assign ctl.insert     = (state_ff == S_DEL) && !rem_any && !full;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [COORD_BITS-1:0] l_ey, r_ey;
      entry_type             l_ent, r_ent;
      logic                  l_lt, r_le;

      if (i == 0) begin : g_head
         assign l_ey  = '0;
         assign l_ent = '0;
         assign l_lt  = 1'b1;
      end else begin : g_left
         assign l_ey  = cell_ey[i-1];
         assign l_ent = cell_ent[i-1];
         assign l_lt  = cell_flag[i-1].lt;
      end

      if (i == LIST_DEPTH - 1) begin : g_tail
         assign r_ey  = '0;
         assign r_ent = '0;
         assign r_le  = 1'b0;
      end else begin : g_right
         assign r_ey  = cell_ey[i+1];
         assign r_ent = cell_ent[i+1];
         assign r_le  = cell_flag[i+1].le;
      end

      acs_cell #(
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key_y    (y_ff),
         .key_sc   (key_sc),
         .new_ey   (y_ff),
         .new_ent  (new_ent),
         .left_ey  (l_ey),
         .left_ent (l_ent),
         .left_lt  (l_lt),
         .right_ey (r_ey),
         .right_ent(r_ent),
         .right_le (r_le),
         .ey       (cell_ey[i]),
         .ent      (cell_ent[i]),
         .flags    (cell_flag[i])
      );

      assign bnd_vec[i]  = cell_flag[i].bnd;
      assign last_vec[i] = cell_flag[i].last;
      assign dom_vec[i]  = cell_flag[i].dom;
      assign rem_vec[i]  = cell_flag[i].rem;
   end

   assign dom_any = |dom_vec;
   assign rem_any = |rem_vec;
   assign full    = cell_ent[LIST_DEPTH-1].valid;

   assign pick_sel = (state_ff == S_LOOK) ? bnd_vec : last_vec;

   acs_pick #(
      .DEPTH(LIST_DEPTH)
   ) u_pick (
      .clock(clock),
      .sel  (pick_sel),
      .ent  (cell_ent),
      .pick (pick)
   );

   assign sum       = {1'b0, pick.score} + (SCORE_W + 1)'(base_ff);
   assign sat_score = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      y_in         = y_ff;
      base_in      = base_ff;
      sc_in        = sc_ff;
      pv_in        = pv_ff;
      ps_in        = ps_ff;
      cs_in        = cs_ff;
      ins_in       = ins_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pv_in    = rsp_pv_ff;
      rsp_ps_in    = rsp_ps_ff;
      rsp_cs_in    = rsp_cs_ff;
      rsp_ins_in   = rsp_ins_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_bs_in    = rsp_bs_ff;
      rsp_bsl_in   = rsp_bsl_ff;
      ram_wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in = action_type'(req_action);
               slot_in   = req_slot;
               idx_in    = slot_index(req_slot);
               y_in      = req_coord_y;
               base_in   = req_base_score;
               pv_in     = 1'b0;
               ps_in     = '0;
               cs_in     = '0;
               ins_in    = 1'b0;
               ovf_in    = 1'b0;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            unique case (action_ff)
               ACT_START: state_in = S_CALC;
               ACT_END: begin
                  cs_in    = ram_rd;
                  sc_in    = ram_rd;
                  state_in = dom_any ? S_BEST : S_DEL;
               end
               ACT_CLEAR, ACT_NONE: state_in = S_BEST;
            endcase
         end
         S_CALC: begin
            pv_in     = pick.found;
            ps_in     = pick.slot;
            cs_in     = sat_score;
            ram_wr_en = 1'b1;
            state_in  = S_BEST;
         end
         S_DEL: begin
            if (!rem_any) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ins_in = 1'b1;
               end
               state_in = S_BEST;
            end
         end
         S_BEST: state_in = S_FIN;
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pv_in    = pv_ff;
               rsp_ps_in    = ps_ff;
               rsp_cs_in    = cs_ff;
               rsp_ins_in   = ins_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_bv_in    = pick.found;
               rsp_bs_in    = pick.score;
               rsp_bsl_in   = pick.slot;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      slot_ff    <= slot_in;
      idx_ff     <= idx_in;
      y_ff       <= y_in;
      base_ff    <= base_in;
      sc_ff      <= sc_in;
      pv_ff      <= pv_in;
      ps_ff      <= ps_in;
      cs_ff      <= cs_in;
      ins_ff     <= ins_in;
      ovf_ff     <= ovf_in;
      rsp_pv_ff  <= rsp_pv_in;
      rsp_ps_ff  <= rsp_ps_in;
      rsp_cs_ff  <= rsp_cs_in;
      rsp_ins_ff <= rsp_ins_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_bv_ff  <= rsp_bv_in;
      rsp_bs_ff  <= rsp_bs_in;
      rsp_bsl_ff <= rsp_bsl_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pred_valid  = rsp_pv_ff;
   assign rsp_pred_slot   = rsp_ps_ff;
   assign rsp_chain_score = rsp_cs_ff;
   assign rsp_inserted    = rsp_ins_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_best_valid  = rsp_bv_ff;
   assign rsp_best_score  = rsp_bs_ff;
   assign rsp_best_slot   = rsp_bsl_ff;

endmodule
`default_nettype wire

### rtl/acs_checker.sv
`default_nettype none
module acs_checker import acs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_pred_valid,
   input logic [SLOT_W-1:0]  rsp_pred_slot,
   input logic [SCORE_W-1:0] rsp_chain_score,
   input logic               rsp_inserted,
   input logic               rsp_overflow,
   input logic               rsp_best_valid,
   input logic [SCORE_W-1:0] rsp_best_score,
   input logic [SLOT_W-1:0]  rsp_best_slot
);

   // stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_pred_valid, rsp_pred_slot, rsp_chain_score, rsp_inserted,
                     rsp_overflow, rsp_best_valid, rsp_best_score, rsp_best_slot}))
      else $error("rsp transfer changed while stalled");

   a_event_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inserted && rsp_overflow)
         && !(rsp_pred_valid && (rsp_inserted || rsp_overflow)))
      else $error("start and end outcomes mixed in one result");

   // list scores rise toward the end, so an insert never tops the best entry
   a_insert_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> rsp_best_valid && (rsp_best_score >= rsp_chain_score))
      else $error("inserted entry not reflected in best entry");

   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_best_valid |-> (rsp_best_score == '0) && (rsp_best_slot == '0)
         && !rsp_inserted)
      else $error("empty list reports a best entry");

   a_no_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pred_valid |-> (rsp_pred_slot == '0))
      else $error("predecessor slot without predecessor");

endmodule

bind alignment_chaining_sweep acs_checker u_acs_checker (.*);
`default_nettype wire
